FILE: rtl/b2da_pkg.sv
// Shared types and constants for the binary to decimal ASCII converter.
// Used by every module under rtl; depends on nothing.
`timescale 1ns / 1ps

package b2da_pkg;

    localparam int VALUE_BITS    = 31;
    localparam int BITS_PER_STEP = 4;
    localparam int CONV_STEPS    = (VALUE_BITS + BITS_PER_STEP - 1) / BITS_PER_STEP;
    localparam int SHIFT_W       = CONV_STEPS * BITS_PER_STEP;
    // upper bound on decimal digits of a VALUE_BITS-bit number: floor(n*log10(2)) + 1
    localparam int NUM_DIGITS    = (VALUE_BITS * 30103) / 100000 + 1;
    localparam int BCD_W         = NUM_DIGITS * 4;
    localparam int DIG_IDX_W     = $clog2(NUM_DIGITS);
    localparam int STEP_CNT_W    = $clog2(CONV_STEPS + 1);
    localparam int CHAR_W        = 6;
    localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;

    // queue depth must be a power of two (pointers wrap freely)
    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [1:0] {
        FR_IDLE,
        FR_CONV,
        FR_PUSH
    } front_state_t;

    // one converted number: BCD digits plus position of the leading digit
    typedef struct packed {
        logic [NUM_DIGITS-1:0][3:0] bcd;
        logic [DIG_IDX_W-1:0]       msd;
    } conv_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_status_t;

endpackage

FILE: rtl/b2da_front.sv
// Front end: accepts a binary value, converts it to BCD with a shift-and-add-3
// loop (several bits per cycle), finds the leading digit, pushes to the queue.
// Depends on b2da_pkg.
`timescale 1ns / 1ps

module b2da_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [b2da_pkg::VALUE_BITS-1:0] value,
    input  b2da_pkg::fifo_status_t        status,
    output logic                          push,
    output b2da_pkg::conv_t               push_data
);
    import b2da_pkg::*;

    front_state_t            state_reg, state_next;
    logic [STEP_CNT_W-1:0]   step_reg, step_next;
    logic [SHIFT_W-1:0]      bin_reg, bin_next;
    logic [BCD_W-1:0]        bcd_reg, bcd_next;
    logic [DIG_IDX_W-1:0]    msd;

    function automatic logic [BCD_W+SHIFT_W-1:0] dabble(
        input logic [BCD_W-1:0]   bcd_in,
        input logic [SHIFT_W-1:0] bin_in
    );
        logic [BCD_W-1:0]   b;
        logic [SHIFT_W-1:0] s;
        b = bcd_in;
        s = bin_in;
        for (int i = 0; i < BITS_PER_STEP; i++) begin
            for (int d = 0; d < NUM_DIGITS; d++) begin
                if (b[d*4 +: 4] >= 4'd5) begin
                    b[d*4 +: 4] = b[d*4 +: 4] + 4'd3;
                end
            end
            b = {b[BCD_W-2:0], s[SHIFT_W-1]};
            s = {s[SHIFT_W-2:0], 1'b0};
        end
        return {b, s};
    endfunction

    // highest nonzero digit; zero input leaves index 0
    always_comb
    begin
        msd = '0;
        for (int d = 0; d < NUM_DIGITS; d++) begin
            if (bcd_reg[d*4 +: 4] != 4'd0) begin
                msd = DIG_IDX_W'(d);
            end
        end
    end

    assign push_data.bcd = bcd_reg;
    assign push_data.msd = msd;
    assign busy          = (state_reg != FR_IDLE);

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        bin_next   = bin_reg;
        bcd_next   = bcd_reg;
        push       = 1'b0;
        case (state_reg)
            FR_IDLE:
            begin
                if (start)
                begin
                    bin_next   = SHIFT_W'(value);
                    bcd_next   = '0;
                    step_next  = STEP_CNT_W'(CONV_STEPS - 1);
                    state_next = FR_CONV;
                end
            end
            FR_CONV:
            begin
                {bcd_next, bin_next} = dabble(bcd_reg, bin_reg);
                if (step_reg == '0)
                begin
                    state_next = FR_PUSH;
                end
                else
                begin
                    step_next = step_reg - 1'b1;
                end
            end
            FR_PUSH:
            begin
                push = !status.full;
                if (!status.full)
                begin
                    state_next = FR_IDLE;
                end
            end
            default:
            begin
                state_next = FR_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FR_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("front did not go busy after accepting a transaction");

    a_push_only_when_room: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (state_reg == FR_PUSH) && !status.full)
        else $error("front pushed outside push state or into a full queue");

endmodule

FILE: rtl/b2da_fifo.sv
// Short queue of converted numbers between front and back ends.
// Depends on b2da_pkg.
`timescale 1ns / 1ps

module b2da_fifo (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  b2da_pkg::conv_t        push_data,
    input  logic                   pop,
    output b2da_pkg::conv_t        pop_data,
    output b2da_pkg::fifo_status_t status
);
    import b2da_pkg::*;

    conv_t                  mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CNT_W-1:0]  count_reg, count_next;
    logic                   do_push, do_pop;

    assign status.full  = (count_reg == FIFO_CNT_W'(FIFO_DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign pop_data     = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FIFO_CNT_W'(FIFO_DEPTH))
        else $error("queue count above depth");

    a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !status.empty)
        else $error("pop from empty queue");

endmodule

FILE: rtl/b2da_back.sv
// Back end: takes converted numbers from the queue and emits one ASCII digit
// per cycle, leading digit first, through registered outputs. Depends on b2da_pkg.
`timescale 1ns / 1ps

module b2da_back (
    input  logic                       clk,
    input  logic                       rst_n,
    input  b2da_pkg::fifo_status_t     status,
    input  b2da_pkg::conv_t            pop_data,
    output logic                       pop,
    output logic                       strobe,
    output logic [b2da_pkg::CHAR_W-1:0] digit_char,
    output logic                       last
);
    import b2da_pkg::*;

    logic                       active_reg, active_next;
    logic [DIG_IDX_W-1:0]       idx_reg, idx_next;
    logic [NUM_DIGITS-1:0][3:0] bcd_reg, bcd_next;
    logic                       strobe_reg, strobe_next;
    logic [CHAR_W-1:0]          char_reg, char_next;
    logic                       last_reg, last_next;
    logic                       run_done;

    assign run_done = !active_reg || (idx_reg == '0);
    assign pop      = run_done && !status.empty;

    always_comb
    begin
        active_next = active_reg;
        idx_next    = idx_reg;
        bcd_next    = bcd_reg;
        strobe_next = active_reg;
        char_next   = ASCII_ZERO + CHAR_W'(bcd_reg[idx_reg]);
        last_next   = (idx_reg == '0);
        if (active_reg && idx_reg != '0)
        begin
            idx_next = idx_reg - 1'b1;
        end
        if (run_done)
        begin
            active_next = pop;
            if (pop)
            begin
                bcd_next = pop_data.bcd;
                idx_next = pop_data.msd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            idx_reg    <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
            idx_reg    <= idx_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bcd_reg  <= bcd_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

    assign strobe     = strobe_reg;
    assign digit_char = char_reg;
    assign last       = last_reg;

    // digits of one run come out without gaps
    a_run_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        strobe_reg && !last_reg |=> strobe_reg)
        else $error("gap inside a digit run");

endmodule

FILE: rtl/binary_to_decimal_ascii_top.sv
// Binary to decimal ASCII converter, top level: front end, queue, back end.
// After accept, the front end runs the shift-and-add-3 loop (4 bits a cycle)
// and pushes the result into the queue; the back end pops it and emits its
// digits through registered outputs, one digit per cycle. The front end stays
// busy until its push, which waits while the queue is full. Receiver cannot stall.
// Async active-low reset clears all control state; no clearing pass.
`timescale 1ns / 1ps

module binary_to_decimal_ascii_top (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [b2da_pkg::VALUE_BITS-1:0] value,
    output logic                            strobe,
    output logic [b2da_pkg::CHAR_W-1:0]     digit_char,
    output logic                            last
);
    import b2da_pkg::*;

    fifo_status_t status;
    conv_t        push_data, pop_data;
    logic         push, pop;

    b2da_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .value     (value),
        .status    (status),
        .push      (push),
        .push_data (push_data)
    );

    b2da_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .status    (status)
    );

    b2da_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .status     (status),
        .pop_data   (pop_data),
        .pop        (pop),
        .strobe     (strobe),
        .digit_char (digit_char),
        .last       (last)
    );

endmodule

FILE: test/tb.sv
// Testbench for binary_to_decimal_ascii_top: drives numbers to convert and
// checks every ASCII digit strobe against a decimal predictor kept here.
// Depends on rtl/b2da_pkg.sv and rtl/binary_to_decimal_ascii_top.sv.
`timescale 1ns / 1ps

module tb;

    import b2da_pkg::*;

    localparam int LIMIT_CYCLES  = 200000;
    localparam int MAX_REPORTS   = 10;
    localparam int DRAIN_CYCLES  = 40;   // margin after the last number, which has up to 10 digits
    localparam int RANDOM_ITEMS  = 346;
    localparam int MAX_GAP       = 18;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
    } digit_t;

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    logic [VALUE_BITS-1:0] value;
    logic                  strobe;
    logic [CHAR_W-1:0]     digit_char;
    logic                  last;

    digit_t pending_digits[$];
    int     numbers_sent;
    int     directed_sent;
    int     digits_checked;
    int     mismatch_count;
    bit     back_to_back;

    binary_to_decimal_ascii_top u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .value      (value),
        .strobe     (strobe),
        .digit_char (digit_char),
        .last       (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    task automatic note_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("MISMATCH @%0t: %s", $realtime, msg);
    endtask

    // Decimal digits of n, most significant first, last flag on the units digit.
    function automatic void predict_digits(input logic [VALUE_BITS-1:0] n);
        logic [3:0]      rev [0:19];
        longint unsigned rest;
        int              count;
        int              k;
        rest  = 64'(n);
        count = 0;
        do
        begin
            rev[count] = 4'(rest % 10);
            count++;
            rest = rest / 10;
        end
        while (rest != 0);
        for (k = count - 1; k >= 0; k--)
            pending_digits.push_back(digit_t'{ch: ASCII_ZERO + CHAR_W'(rev[k]),
                                              last: (k == 0)});
    endfunction

    // One transaction: random idle gap, then hold start until busy is low at an edge.
    task automatic send_value(input logic [VALUE_BITS-1:0] n);
        int gap;
        gap = back_to_back ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            start <= 1'b0;
            value <= VALUE_BITS'($urandom);
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        value <= n;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        predict_digits(n);
        numbers_sent++;
    endtask

    task automatic test_edge_values;
        send_value('0);
        send_value(VALUE_BITS'(1));
        send_value(VALUE_BITS'(9));
        send_value(VALUE_BITS'(10));
        send_value('1);
        send_value(VALUE_BITS'(1) << (VALUE_BITS - 1));
        send_value(VALUE_BITS'(32'h2AAA_AAAA));
        send_value(VALUE_BITS'(32'h5555_5555));
    endtask

    // Digit count boundaries: 10^k - 1 and 10^k for k = 2 to 9.
    task automatic test_digit_counts;
        longint unsigned p;
        int              k;
        p = 10;
        for (k = 2; k <= 9; k++)
        begin
            p = p * 10;
            send_value(VALUE_BITS'(p - 1));
            send_value(VALUE_BITS'(p));
        end
    endtask

    task automatic test_random(input int count);
        logic [VALUE_BITS-1:0] n;
        int                    i;
        int                    w;
        for (i = 0; i < count; i++)
        begin
            if (i % 40 == 0)
                back_to_back = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 3))
                0: n = VALUE_BITS'($urandom);
                3: n = VALUE_BITS'($urandom_range(0, 99));
                default:
                begin
                    // spread over digit counts rather than clustering at ten digits
                    w = $urandom_range(1, VALUE_BITS);
                    n = VALUE_BITS'($urandom) >> (VALUE_BITS - w);
                end
            endcase
            send_value(n);
        end
        back_to_back = 1'b0;
    endtask

    always @(posedge clk)
    begin
        digit_t got;
        digit_t want;
        if (rst_n && strobe === 1'b1)
        begin
            got = digit_t'{ch: digit_char, last: last};
            if (pending_digits.size() == 0)
                note_mismatch($sformatf("unexpected digit char %0d last %b", got.ch, got.last));
            else
            begin
                want = pending_digits.pop_front();
                digits_checked++;
                if (got.ch !== want.ch || got.last !== want.last)
                    note_mismatch($sformatf("digit char exp %0d got %0d, last exp %b got %b",
                                            want.ch, got.ch, want.last, got.last));
            end
        end
    end

    initial
    begin
        repeat (LIMIT_CYCLES) @(posedge clk);
        $display("timeout with %0d digits outstanding", pending_digits.size());
        $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        rst_n          = 1'b0;
        start          = 1'b0;
        value          = '0;
        back_to_back   = 1'b0;
        numbers_sent   = 0;
        digits_checked = 0;
        mismatch_count = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_edge_values();
        test_digit_counts();
        directed_sent = numbers_sent;
        test_random(RANDOM_ITEMS);
        start <= 1'b0;

        while (pending_digits.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("converted %0d numbers (%0d directed, %0d random) covering 1 to 10 digits",
                 numbers_sent, directed_sent, numbers_sent - directed_sent);
        $display("checked %0d digit strobes, %0d mismatches", digits_checked, mismatch_count);
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
